// ----- rtl/pwm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwm_pkg
// Types, geometry and codes shared by the paged word memory.
// ----------------------------------------------------------------------------
package pwm_pkg;

  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned NUM_PAGES   = 16;
  localparam int unsigned WORD_BYTES  = 8;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SIZE_W      = 32;

  localparam int unsigned STORE_BYTES = PAGE_BYTES * NUM_PAGES;
  localparam int unsigned WORD_W      = 8 * WORD_BYTES;
  localparam int unsigned OFS_W       = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned LANE_W      = $clog2(WORD_BYTES);
  localparam int unsigned PR_W        = OFS_W - LANE_W;     // rows per page, log2
  localparam int unsigned ROW_W       = PG_W + PR_W;        // row index in one bank
  localparam int unsigned ST_W        = PG_W + OFS_W;       // byte index in the store
  localparam int unsigned ROWS        = STORE_BYTES / WORD_BYTES;
  localparam int unsigned PN_W        = ADDR_W - OFS_W;     // page number width
  localparam int unsigned CNT_W       = SIZE_W + 1 - OFS_W; // page count width

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_UNALIGNED = 2'd2,
    ST_SIZE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic        [1:0]        operation;
    logic        [ADDR_W-1:0] address;
    logic signed [DATA_W-1:0] write_data;
    logic        [SIZE_W-1:0] alloc_size;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    status_e                  status;
  } res_t;

endpackage

// ----- rtl/pwm_ram.sv -----
// ----------------------------------------------------------------------------
// pwm_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pwm_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ----- rtl/paged_word_memory.sv -----
// ----------------------------------------------------------------------------
// paged_word_memory
// Byte-addressed paged store with a page map: word read, word write and
// page allocation.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   Its result shows on result_o for exactly one cycle, marked by done_o;
//   the receiver cannot stall it and must take it in that cycle.
//   Read and write: result in the cycle after the transfer, busy stays low,
//   so one command per cycle is sustained. The word is spread over one
//   byte-wide RAM bank per byte lane; each bank is touched once per access,
//   and the read data comes from the banks' registered outputs.
//   Allocate: busy rises while each page in the range is scanned and each new
//   page is zeroed row by row (one row of all banks is zeroed per cycle),
//   and the result follows in the cycle busy falls.
//   A rejected allocation answers in the next cycle without going busy.
//   Reset: asynchronous, marks every page absent. Store contents are not
//   cleared; a page is zeroed when it is first allocated, so no clearing
//   pass runs after reset.
// ----------------------------------------------------------------------------
module paged_word_memory (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  pwm_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output pwm_pkg::res_t result_o
);

  import pwm_pkg::*;

  state_e                  state_q, state_d;
  logic [NUM_PAGES-1:0]    present_q;
  logic [PG_W-1:0]         pg_q, pg_last_q;
  logic [PR_W-1:0]         row_q;
  logic                    done_q, rd_q;
  status_e                 status_q;
  logic [LANE_W-1:0]       lane_q;

  // command decode
  logic [PN_W-1:0]   page_num;
  logic [OFS_W-1:0]  offset;
  logic [PG_W-1:0]   page_idx;
  logic              in_store, acc_ok;
  logic [CNT_W-1:0]  page_cnt;
  logic [PG_W:0]     room;
  logic              alloc_ok, alloc_unal;
  logic [PG_W-1:0]   alloc_last;
  status_e           cmd_status;
  logic [ST_W-1:0]   store_addr;
  logic [ROW_W-1:0]  row_base;
  logic [LANE_W-1:0] lane;

  assign page_num   = cmd_i.address[ADDR_W-1:OFS_W];
  assign offset     = cmd_i.address[OFS_W-1:0];
  assign page_idx   = page_num[PG_W-1:0];
  assign in_store   = page_num < PN_W'(NUM_PAGES);
  assign acc_ok     = in_store && present_q[page_idx] &&
                      (offset <= OFS_W'(PAGE_BYTES - WORD_BYTES));
  assign page_cnt   = CNT_W'(((SIZE_W+1)'(cmd_i.alloc_size) +
                              (SIZE_W+1)'(PAGE_BYTES - 1)) >> OFS_W);
  assign room       = (PG_W+1)'(NUM_PAGES) - {1'b0, page_idx};
  assign alloc_unal = offset != '0;
  assign alloc_ok   = !alloc_unal && (cmd_i.alloc_size != '0) && in_store &&
                      (page_cnt <= CNT_W'(room));
  assign alloc_last = page_idx + PG_W'(page_cnt - CNT_W'(1));
  assign store_addr = {page_idx, offset};
  assign row_base   = store_addr[ST_W-1:LANE_W];
  assign lane       = offset[LANE_W-1:0];

  always_comb begin
    case (cmd_i.operation)
      OP_READ, OP_WRITE: cmd_status = acc_ok ? ST_OK : ST_RANGE;
      OP_ALLOC: begin
        if (alloc_unal) begin
          cmd_status = ST_UNALIGNED;
        end else begin
          cmd_status = alloc_ok ? ST_OK : ST_SIZE;
        end
      end
      default: cmd_status = ST_OK;
    endcase
  end

  // sequencer control
  logic accept, alloc_go, mem_rd, mem_wr, clearing;
  logic alloc_fin, pg_step, page_mark;
  logic page_here, pg_at_last, row_at_last;

  assign page_here   = present_q[pg_q];
  assign pg_at_last  = pg_q == pg_last_q;
  assign row_at_last = row_q == '1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && cmd_i.operation == OP_ALLOC && alloc_ok) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!page_here) begin
          state_d = S_CLEAR;
        end else if (pg_at_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (row_at_last) begin
          state_d = pg_at_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    accept    = 1'b0;
    alloc_go  = 1'b0;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    clearing  = 1'b0;
    alloc_fin = 1'b0;
    pg_step   = 1'b0;
    page_mark = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        accept   = start;
        alloc_go = start && cmd_i.operation == OP_ALLOC && alloc_ok;
        mem_rd   = start && cmd_i.operation == OP_READ && acc_ok;
        mem_wr   = start && cmd_i.operation == OP_WRITE && acc_ok;
      end
      S_SCAN: begin
        alloc_fin = page_here && pg_at_last;
        pg_step   = page_here && !pg_at_last;
      end
      S_CLEAR: begin
        clearing  = 1'b1;
        page_mark = row_at_last;
        alloc_fin = row_at_last && pg_at_last;
        pg_step   = row_at_last && !pg_at_last;
      end
      default: ;
    endcase
  end

  // byte lanes: byte i of the word lives in bank (lane + i) mod WORD_BYTES
  logic [ROW_W-1:0] bank_addr  [WORD_BYTES];
  logic [7:0]       bank_wdata [WORD_BYTES];
  logic [7:0]       bank_rdata [WORD_BYTES];

  for (genvar k = 0; k < WORD_BYTES; k++) begin : g_bank
    logic [LANE_W-1:0] sel;
    assign sel           = LANE_W'(k) - lane;
    // banks below the start lane take their byte from the next row
    assign bank_addr[k]  = clearing ? {pg_q, row_q}
                                    : row_base + ROW_W'(LANE_W'(k) < lane);
    assign bank_wdata[k] = clearing ? 8'h00 : cmd_i.write_data[{sel, 3'b000} +: 8];

    pwm_ram #(
      .DEPTH(ROWS),
      .WIDTH(8)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (clearing | mem_wr),
      .re_i   (mem_rd),
      .addr_i (bank_addr[k]),
      .wdata_i(bank_wdata[k]),
      .rdata_o(bank_rdata[k])
    );
  end

  logic signed [WORD_W-1:0] word;

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      word[8*i +: 8] = bank_rdata[LANE_W'(LANE_W'(i) + lane_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      present_q <= '0;
      pg_q      <= '0;
      pg_last_q <= '0;
      row_q     <= '0;
      done_q    <= 1'b0;
      rd_q      <= 1'b0;
      status_q  <= ST_OK;
      lane_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (accept && !alloc_go) || alloc_fin;
      rd_q    <= mem_rd;
      if (accept) begin
        status_q <= cmd_status;
        lane_q   <= lane;
      end
      if (alloc_go) begin
        pg_q      <= page_idx;
        pg_last_q <= alloc_last;
        row_q     <= '0;
      end
      if (clearing) begin
        row_q <= row_q + PR_W'(1);
      end
      if (pg_step) begin
        pg_q <= pg_q + PG_W'(1);
      end
      if (page_mark) begin
        present_q[pg_q] <= 1'b1;
      end
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;

  always_comb begin
    result_o.read_data = rd_q ? DATA_W'(word) : '0;
    result_o.status    = status_q;
  end

endmodule

// ----- rtl/pwm_checker.sv -----
// ----------------------------------------------------------------------------
// pwm_checker
// Port-level checks on the paged word memory, bound to the top level.
// ----------------------------------------------------------------------------
module pwm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_i,
  input pwm_pkg::cmd_t cmd_i,
  input logic          done_i,
  input pwm_pkg::res_t result_i
);

  import pwm_pkg::*;

  // word accesses and unused operations answer in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && cmd_i.operation != OP_ALLOC |=> done_i)
    else $error("word access result missing");

  // an unaligned allocation is rejected at once without going busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && cmd_i.operation == OP_ALLOC &&
    cmd_i.address[OFS_W-1:0] != '0
    |=> done_i && !busy_i && result_i.status == ST_UNALIGNED)
    else $error("unaligned allocation not rejected");

  // any failed command returns zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && result_i.status != ST_OK |-> result_i.read_data == '0)
    else $error("nonzero data on a failed command");

  // a result never shows while the sequencer is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result while busy");

endmodule

bind paged_word_memory pwm_checker u_pwm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .cmd_i   (cmd_i),
  .done_i  (done_o),
  .result_i(result_o)
);

// ----- tb/paged_word_memory_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_word_memory_tb
// Self-checking bench for the paged word memory. A local copy of the page map
// and byte store predicts every result. Directed cases cover the fault and
// allocation rules, then random reads, writes and allocations with random idle gaps.
// ----------------------------------------------------------------------------
module paged_word_memory_tb;
  import pwm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  cmd_t  cmd;
  logic  busy;
  logic  done;
  res_t  result;

  // shadow of the block's state
  logic [7:0] byte_image [STORE_BYTES];
  bit         page_map   [NUM_PAGES];
  res_t       expected_results[$];

  bit          burst_mode;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned stall_cycles;
  int unsigned n_reads, n_writes, n_allocs, n_other, n_faults;
  logic [ADDR_W-1:0] last_write_addr;

  paged_word_memory u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd),
    .busy     (busy),
    .done_o   (done),
    .result_o (result)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic cmd_t make_cmd(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                    logic [DATA_W-1:0] wdata, logic [SIZE_W-1:0] size);
    cmd_t c;
    c.operation  = op;
    c.address    = addr;
    c.write_data = wdata;
    c.alloc_size = size;
    return c;
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic res_t apply_command(cmd_t c);
    res_t              r;
    logic [63:0]       pg;
    logic [63:0]       ofs;
    logic [63:0]       cnt;
    logic [DATA_W-1:0] word;
    int unsigned       base;
    r.read_data = '0;
    r.status    = ST_OK;
    pg  = c.address / PAGE_BYTES;
    ofs = c.address % PAGE_BYTES;
    case (c.operation)
      OP_READ, OP_WRITE: begin
        if (c.operation == OP_READ) n_reads++;
        else n_writes++;
        if (pg >= NUM_PAGES || !page_map[pg[PG_W-1:0]] ||
            ofs > PAGE_BYTES - WORD_BYTES) begin
          r.status = ST_RANGE;
          n_faults++;
        end else begin
          base = 32'(pg * PAGE_BYTES + ofs);
          if (c.operation == OP_WRITE) begin
            for (int i = 0; i < WORD_BYTES; i++)
              byte_image[base + i] = c.write_data[8*i +: 8];
          end else begin
            word = '0;
            for (int i = 0; i < WORD_BYTES; i++)
              word[8*i +: 8] = byte_image[base + i];
            if (WORD_W < DATA_W && word[WORD_W-1])
              word = word | ~((64'd1 << WORD_W) - 64'd1);
            r.read_data = word;
          end
        end
      end
      OP_ALLOC: begin
        n_allocs++;
        cnt = (64'(c.alloc_size) + PAGE_BYTES - 1) / PAGE_BYTES;
        if (ofs != 0)
          r.status = ST_UNALIGNED;
        else if (c.alloc_size == 0)
          r.status = ST_SIZE;
        else if (pg >= NUM_PAGES || cnt > NUM_PAGES - pg)
          r.status = ST_SIZE;
        else begin
          for (int p = int'(pg); p < int'(pg + cnt); p++) begin
            if (!page_map[p]) begin
              for (int b = 0; b < PAGE_BYTES; b++)
                byte_image[p*PAGE_BYTES + b] = 8'h00;
              page_map[p] = 1'b1;
            end
          end
        end
        if (r.status != ST_OK) n_faults++;
      end
      default: n_other++;
    endcase
    return r;
  endfunction

  // Predicts on each transfer, checks each result against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (done) begin
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: read_data=%h status=%0d",
                   $time, result.read_data, result.status);
      end else begin
        want = expected_results.pop_front();
        if (result.read_data !== want.read_data || result.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: read_data exp %h got %h, status exp %0d got %0d",
                     $time, want.read_data, result.read_data, want.status, result.status);
        end
      end
    end
    if (rst_ni && start && !busy)
      expected_results.push_back(apply_command(cmd));
  end

  // Ends a hung run.
  always @(posedge clk_i) begin
    if ((start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_command(input cmd_t c);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic issue(logic [1:0] op, logic [ADDR_W-1:0] addr,
                       logic [DATA_W-1:0] wdata, logic [SIZE_W-1:0] size);
    send_command(make_cmd(op, addr, wdata, size));
  endtask

  task automatic test_absent_pages();
    issue(OP_READ,  64'h0,   64'h0, 32'd0);
    issue(OP_WRITE, 64'h100, 64'h1122_3344_5566_7788, 32'd0);
  endtask

  task automatic test_alloc_checks();
    issue(OP_ALLOC, 64'h10,  64'h0, 32'd256);
    issue(OP_ALLOC, 64'h201, 64'h0, 32'd0);   // alignment is checked before size
    issue(OP_ALLOC, 64'h0,   64'h0, 32'd0);
    issue(OP_ALLOC, 64'(15 * PAGE_BYTES), 64'h0, 32'(PAGE_BYTES + 1));
    issue(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 32'd1);
    issue(OP_ALLOC, 64'h0,   64'h0, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 64'h0,   64'h0, 32'd1);
    issue(OP_ALLOC, 64'(14 * PAGE_BYTES), 64'h0, 32'(2 * PAGE_BYTES));
  endtask

  task automatic test_word_access();
    issue(OP_READ,  64'h0, 64'h0, 32'd0);
    issue(OP_WRITE, 64'h0, 64'h8000_0000_0000_0001, 32'd0);
    issue(OP_READ,  64'h0, 64'h0, 32'd0);
    issue(OP_WRITE, 64'h3, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);  // unaligned, inside page
    issue(OP_READ,  64'h0, 64'h0, 32'd0);
    issue(OP_WRITE, 64'(PAGE_BYTES - WORD_BYTES), 64'h0123_4567_89AB_CDEF, 32'd0);
    issue(OP_READ,  64'(PAGE_BYTES - WORD_BYTES), 64'h0, 32'd0);
  endtask

  task automatic test_page_bounds();
    issue(OP_READ,  64'(PAGE_BYTES - WORD_BYTES + 1), 64'h0, 32'd0);
    issue(OP_WRITE, 64'(PAGE_BYTES - 1), 64'h5A5A_5A5A_5A5A_5A5A, 32'd0);
    issue(OP_READ,  64'(STORE_BYTES), 64'h0, 32'd0);
    issue(OP_READ,  64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 32'd0);
    // reallocating a present page keeps its data
    issue(OP_ALLOC, 64'h0, 64'h0, 32'(PAGE_BYTES));
    issue(OP_READ,  64'h0, 64'h0, 32'd0);
  endtask

  task automatic test_unused_op();
    issue(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    cmd_t        c;
    int unsigned sel;
    int unsigned top_page;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      // for the first half, allocations placed inside the store start in the lower half of the pages
      top_page = (i < RANDOM_ITEMS / 2) ? NUM_PAGES / 2 - 1 : NUM_PAGES - 1;
      c.write_data = {$urandom, $urandom};
      c.alloc_size = $urandom;
      c.address    = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 88) begin
        c.operation = (sel < 46) ? OP_READ : OP_WRITE;
        sel = $urandom_range(0, 99);
        if (c.operation == OP_READ && sel < 35)
          c.address = last_write_addr;
        else if (sel < 85)
          c.address = 64'($urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES +
                          $urandom_range(0, PAGE_BYTES - WORD_BYTES));
        else if (sel < 93)
          c.address = 64'($urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES +
                          $urandom_range(PAGE_BYTES - WORD_BYTES + 1, PAGE_BYTES - 1));
        else if (sel < 97)
          c.address = 64'($urandom_range(STORE_BYTES, 4 * STORE_BYTES));
        if (c.operation == OP_WRITE) last_write_addr = c.address;
      end else if (sel < 96) begin
        c.operation = OP_ALLOC;
        sel = $urandom_range(0, 99);
        if (sel < 85)
          c.address = 64'($urandom_range(0, top_page) * PAGE_BYTES);
        else if (sel < 90)
          c.address = 64'($urandom_range(NUM_PAGES, 64) * PAGE_BYTES);
        else if (sel < 95)
          c.address = 64'($urandom_range(0, STORE_BYTES - 1) | 1);
        sel = $urandom_range(0, 99);
        if (sel < 60)
          c.alloc_size = $urandom_range(1, 2 * PAGE_BYTES);
        else if (sel < 80)
          c.alloc_size = $urandom_range(0, STORE_BYTES);
        else if (sel < 90)
          c.alloc_size = '0;
      end else begin
        c.operation = 2'($urandom_range(0, 3));
      end
      send_command(c);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    cmd    <= '0;
    burst_mode = 1'b0;
    last_write_addr = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_absent_pages();
    test_alloc_checks();
    test_word_access();
    test_page_bounds();
    test_unused_op();
    test_random_traffic();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d reads, %0d writes, %0d allocations, %0d unused ops; %0d faults",
             n_reads, n_writes, n_allocs, n_other, n_faults);
    $display("Checked %0d results, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
